/* design/state_variable_filter_top_macros.svh */
// Assertion macros used by the checker file of the state-variable filter.
`ifndef STATE_VARIABLE_FILTER_TOP_MACROS_SVH
`define STATE_VARIABLE_FILTER_TOP_MACROS_SVH

// Generic clocked assertion with an active-low reset that disables checking.
`define SVF_ASSERT_PROP(lbl, ck, rstn, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) prop) else $error(msg);

// A signal holds its value over a cycle in which a beat is offered but not taken.
`define SVF_ASSERT_HELD(lbl, ck, rstn, vld, rdy, sig, msg) \
    `SVF_ASSERT_PROP(lbl, ck, rstn, (vld && !rdy) |=> $stable(sig), msg)

`endif

/* design/svf_pkg.sv */
// Shared types, constants and helper functions of the state-variable filter.
`default_nettype none

package svf_pkg;

    localparam int SAMPLE_WIDTH   = 24;
    localparam int CODE_WIDTH     = 8;
    localparam int MASK_WIDTH     = 4;
    localparam int COEF_WIDTH     = 2 * CODE_WIDTH;
    localparam int ACC_WIDTH      = SAMPLE_WIDTH + COEF_WIDTH + 2;
    localparam int CFG_IDX_WIDTH  = 2;
    localparam int CFG_DATA_WIDTH = CODE_WIDTH;

    localparam int COEF_F_SHIFT = 14;
    localparam int COEF_Q_SHIFT = 7;

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic signed [ACC_WIDTH-1:0]    acc_t;
    typedef logic [COEF_WIDTH-1:0]          coef_t;
    typedef logic [CODE_WIDTH-1:0]          code_t;
    typedef logic [MASK_WIDTH-1:0]          mask_t;
    typedef logic [CFG_IDX_WIDTH-1:0]       cfg_index_t;
    typedef logic [CFG_DATA_WIDTH-1:0]      cfg_data_t;

    // Register indexes of the configuration port.
    localparam cfg_index_t CFG_CUTOFF    = 2'd0;
    localparam cfg_index_t CFG_RESONANCE = 2'd1;
    localparam cfg_index_t CFG_TAP_MASK  = 2'd2;

    localparam code_t CUTOFF_RESET    = 8'd64;
    localparam code_t RESONANCE_RESET = 8'd128;
    localparam mask_t TAP_MASK_RESET  = 4'd1;

    // Bit positions in the tap mask.
    localparam int TAP_LOW  = 0;
    localparam int TAP_HIGH = 1;
    localparam int TAP_BAND = 2;
    localparam int TAP_PEAK = 3;

    // Rounding applied by the shared multiplier to its product.
    typedef enum logic [1:0] {
        RND_NONE,
        RND_Q,
        RND_F
    } rnd_sel_t;

    typedef struct packed {
        coef_t    coef;
        sample_t  data;
        rnd_sel_t rnd;
    } mul_req_t;

    localparam acc_t SAT_MAX =
        {{(ACC_WIDTH - SAMPLE_WIDTH + 1){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
    localparam acc_t SAT_MIN =
        {{(ACC_WIDTH - SAMPLE_WIDTH + 1){1'b1}}, {(SAMPLE_WIDTH - 1){1'b0}}};

    function automatic acc_t sext(input sample_t v);
        return acc_t'(v);
    endfunction

    function automatic sample_t sat(input acc_t v);
        sample_t r;
        if (v > SAT_MAX)
            r = SAT_MAX[SAMPLE_WIDTH-1:0];
        else if (v < SAT_MIN)
            r = SAT_MIN[SAMPLE_WIDTH-1:0];
        else
            r = v[SAMPLE_WIDTH-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

/* design/svf_if.sv */
// Handshake channel interfaces of the state-variable filter: samples in, results out, config.
`default_nettype none

interface svf_in_if;
    import svf_pkg::*;

    logic    valid;
    logic    ready;
    sample_t sample_in;
    logic    note_active;

    modport source (output valid, output sample_in, output note_active, input ready);
    modport sink   (input valid, input sample_in, input note_active, output ready);
endinterface

interface svf_out_if;
    import svf_pkg::*;

    logic    valid;
    logic    ready;
    sample_t sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

interface svf_cfg_if;
    import svf_pkg::*;

    logic       valid;
    logic       ready;
    cfg_index_t index;
    cfg_data_t  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* design/state_variable_filter_top.sv */
// Top level of the Chamberlin state-variable filter, one audio sample per beat.
// An active sample passes through seven sequencer states (four multiplier passes) after the
// accepting idle state; its result becomes valid as the engine returns to idle, ready again.
// An inactive sample goes straight from idle to the output state and back.
// A full result slot holds the engine in its output state. Reset clears the filter state and
// loads the register defaults (cutoff 64, resonance 128, tap mask 1); no clearing pass.
`default_nettype none

module state_variable_filter_top (
    input  wire  clk,
    input  wire  rst_n,
    svf_in_if.sink    samples,
    svf_out_if.source results,
    svf_cfg_if.sink   cfg
);
    import svf_pkg::*;

    // The sequencer walks one sample through the shared multiplier. Each multiply is
    // issued in one state and its registered product is consumed in the next.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SQR,
        S_LOW_MUL,
        S_LOW_ADD,
        S_HIGH_ADD,
        S_BAND_MUL,
        S_BAND_ADD,
        S_OUT
    } state_t;

    state_t  state_reg, state_next;

    // Configuration registers.
    code_t   cutoff_reg, cutoff_next;
    code_t   resonance_reg, resonance_next;
    mask_t   mask_reg, mask_next;

    // Filter state.
    sample_t low_reg, low_next;
    sample_t band_reg, band_next;
    sample_t high_reg, high_next;

    // Result register, which frees the engine while a finished result waits.
    logic    out_valid_reg, out_valid_next;
    sample_t out_data_reg, out_data_next;

    // Per-sample payload captured at acceptance, and the squared cutoff.
    sample_t x_reg, x_next;
    logic    active_reg, active_next;
    coef_t   f_reg, f_next;

    mul_req_t mul_req;
    acc_t     prod_reg;
    acc_t     tap_sum;
    logic     out_free;

    svf_mul u_mul (
        .clk      (clk),
        .req      (mul_req),
        .prod_reg (prod_reg)
    );

    assign samples.ready = (state_reg == S_IDLE);
    assign cfg.ready     = 1'b1;
    assign results.valid      = out_valid_reg;
    assign results.sample_out = out_data_reg;

    // The result slot can take a new value when empty or when it drains this cycle.
    assign out_free = !out_valid_reg || results.ready;

    // Sum of the selected taps. The peak tap is low minus high, using the updated taps.
    always_comb
    begin
        tap_sum = '0;
        if (mask_reg[TAP_LOW])
            tap_sum = tap_sum + sext(low_reg);
        if (mask_reg[TAP_HIGH])
            tap_sum = tap_sum + sext(high_reg);
        if (mask_reg[TAP_BAND])
            tap_sum = tap_sum + sext(band_reg);
        if (mask_reg[TAP_PEAK])
            tap_sum = tap_sum + sext(low_reg) - sext(high_reg);
    end

    always_comb
    begin
        state_next     = state_reg;
        cutoff_next    = cutoff_reg;
        resonance_next = resonance_reg;
        mask_next      = mask_reg;
        low_next       = low_reg;
        band_next      = band_reg;
        high_next      = high_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        x_next         = x_reg;
        active_next    = active_reg;
        f_next         = f_reg;

        mul_req.coef = '0;
        mul_req.data = '0;
        mul_req.rnd  = RND_NONE;

        // A result beat leaves the slot when the sink takes it.
        if (out_valid_reg && results.ready)
            out_valid_next = 1'b0;

        // Configuration writes; only the low bits of the data are kept for narrow registers.
        if (cfg.valid)
        begin
            case (cfg.index)
                CFG_CUTOFF:    cutoff_next    = cfg.data[CODE_WIDTH-1:0];
                CFG_RESONANCE: resonance_next = cfg.data[CODE_WIDTH-1:0];
                CFG_TAP_MASK:  mask_next      = cfg.data[MASK_WIDTH-1:0];
                default:       ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (samples.valid)
                begin
                    x_next      = samples.sample_in;
                    active_next = samples.note_active;
                    // An inactive note skips the filter and leaves its state alone.
                    state_next  = samples.note_active ? S_SQR : S_OUT;
                end
            end
            S_SQR:
            begin
                // The tuning coefficient is the cutoff code squared, 14 fraction bits.
                mul_req.coef = {{(COEF_WIDTH - CODE_WIDTH){1'b0}}, cutoff_reg};
                mul_req.data = {{(SAMPLE_WIDTH - CODE_WIDTH){1'b0}}, cutoff_reg};
                mul_req.rnd  = RND_NONE;
                state_next   = S_LOW_MUL;
            end
            S_LOW_MUL:
            begin
                f_next       = prod_reg[COEF_WIDTH-1:0];
                mul_req.coef = prod_reg[COEF_WIDTH-1:0];
                mul_req.data = band_reg;
                mul_req.rnd  = RND_F;
                state_next   = S_LOW_ADD;
            end
            S_LOW_ADD:
            begin
                low_next     = sat(sext(low_reg) + prod_reg);
                // Damping term uses the old band value, like the low update.
                mul_req.coef = {{(COEF_WIDTH - CODE_WIDTH){1'b0}}, resonance_reg};
                mul_req.data = band_reg;
                mul_req.rnd  = RND_Q;
                state_next   = S_HIGH_ADD;
            end
            S_HIGH_ADD:
            begin
                high_next  = sat(sext(x_reg) - sext(low_reg) - prod_reg);
                state_next = S_BAND_MUL;
            end
            S_BAND_MUL:
            begin
                mul_req.coef = f_reg;
                mul_req.data = high_reg;
                mul_req.rnd  = RND_F;
                state_next   = S_BAND_ADD;
            end
            S_BAND_ADD:
            begin
                band_next  = sat(sext(band_reg) + prod_reg);
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // Wait here until the result slot is free, then load it.
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = active_reg ? sat(tap_sum) : x_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cutoff_reg    <= CUTOFF_RESET;
            resonance_reg <= RESONANCE_RESET;
            mask_reg      <= TAP_MASK_RESET;
            low_reg       <= '0;
            band_reg      <= '0;
            high_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cutoff_reg    <= cutoff_next;
            resonance_reg <= resonance_next;
            mask_reg      <= mask_next;
            low_reg       <= low_next;
            band_reg      <= band_next;
            high_reg      <= high_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    // Payload registers of the sample in flight; they are always written before use.
    always_ff @(posedge clk)
    begin
        x_reg      <= x_next;
        active_reg <= active_next;
        f_reg      <= f_next;
    end

endmodule

`default_nettype wire

/* design/svf_mul.sv */
// Shared multiplier of the filter: coefficient times sample, rounded and registered.
`default_nettype none

module svf_mul (
    input  wire                clk,
    input  svf_pkg::mul_req_t  req,
    output svf_pkg::acc_t      prod_reg
);
    import svf_pkg::*;

    localparam acc_t HALF_F = acc_t'(1) <<< (COEF_F_SHIFT - 1);
    localparam acc_t HALF_Q = acc_t'(1) <<< (COEF_Q_SHIFT - 1);

    logic signed [COEF_WIDTH:0]              coef_s;
    logic signed [COEF_WIDTH+SAMPLE_WIDTH:0] prod_raw;
    acc_t                                    prod_ext;
    acc_t                                    prod_next;

    assign coef_s   = $signed({1'b0, req.coef});
    assign prod_raw = coef_s * req.data;
    assign prod_ext = acc_t'(prod_raw);

    // Round to nearest with ties toward plus infinity: add half, then floor. RND_NONE passes the product through.
    always_comb
    begin
        case (req.rnd)
            RND_F:   prod_next = (prod_ext + HALF_F) >>> COEF_F_SHIFT;
            RND_Q:   prod_next = (prod_ext + HALF_Q) >>> COEF_Q_SHIFT;
            RND_NONE: prod_next = prod_ext;
            default: prod_next = prod_ext;
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

endmodule

`default_nettype wire

/* design/svf_checker.sv */
// Port-level checker of the state-variable filter and its bind to the top level.
`default_nettype none
`include "state_variable_filter_top_macros.svh"

module svf_checker (
    input wire              clk,
    input wire              rst_n,
    input wire              in_valid,
    input wire              in_ready,
    input wire              note_active,
    input svf_pkg::sample_t sample_in,
    input wire              out_valid,
    input wire              out_ready,
    input svf_pkg::sample_t sample_out
);
    import svf_pkg::*;

    `SVF_ASSERT_HELD(a_out_valid_held, clk, rst_n, out_valid, out_ready, out_valid, "result beat dropped while stalled")
    `SVF_ASSERT_HELD(a_out_data_held, clk, rst_n, out_valid, out_ready, sample_out, "result changed while stalled")
    `SVF_ASSERT_PROP(a_busy_after_accept, clk, rst_n, (in_valid && in_ready) |=> !in_ready, "engine took a second sample while busy")
    `SVF_ASSERT_PROP(a_pass_through, clk, rst_n, (in_valid && in_ready && !note_active && !out_valid) |=> ##1 (out_valid && sample_out == $past(sample_in, 2)), "inactive note did not pass through")

endmodule

bind state_variable_filter_top svf_checker u_svf_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (samples.valid),
    .in_ready    (samples.ready),
    .note_active (samples.note_active),
    .sample_in   (samples.sample_in),
    .out_valid   (results.valid),
    .out_ready   (results.ready),
    .sample_out  (results.sample_out)
);

`default_nettype wire

/* sim/tb.sv */
// Self-checking testbench for the state-variable filter top level.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import svf_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 2;
    localparam int IDLE_PERCENT   = 14;
    // Cycles allowed to pass once nothing is expected. The margin is longer than the time
    // the block needs for one active sample, so it covers anything still in flight.
    localparam int DRAIN_CYCLES   = 12;
    localparam int HOLD_OFF_LEN   = 300;
    localparam int PRESSURE_ITEMS = 40;
    localparam int RANDOM_ITEMS   = 1300;
    // Longest legal stretch without any beat is the receiver hold-off plus one
    // sample time, so this limit is several times the slowest correct run.
    localparam int WATCHDOG_LIMIT = 2000;

    // Register index that the block does not decode.
    localparam cfg_index_t CFG_UNUSED = 2'd3;

    localparam longint SAMPLE_MAX = (longint'(1) <<< (SAMPLE_WIDTH - 1)) - 1;
    localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;
    localparam sample_t UNIT      = sample_t'(longint'(1) <<< 20);

    logic clk = 1'b0;
    logic rst_n;

    svf_in_if  sample_ch ();
    svf_out_if result_ch ();
    svf_cfg_if cfg_ch ();

    state_variable_filter_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (sample_ch),
        .results (result_ch),
        .cfg     (cfg_ch)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Our own copy of the filter registers and of the three integrator taps.
    code_t   cutoff_reg    = CUTOFF_RESET;
    code_t   resonance_reg = RESONANCE_RESET;
    mask_t   tap_mask_reg  = TAP_MASK_RESET;
    sample_t low_state     = '0;
    sample_t band_state    = '0;
    sample_t high_state    = '0;

    // Filter outputs still owed by the block, oldest first.
    sample_t expected_out[$];

    int          error_count   = 0;
    int          stall_cycles  = 0;
    int unsigned hold_off_left = 0;
    // When set, neither side inserts random idle cycles.
    bit          quiet         = 1'b0;

    // Clamp a wide intermediate value to the signed sample range.
    function automatic longint clamp_sample(longint v);
        if (v > SAMPLE_MAX)
            return SAMPLE_MAX;
        if (v < SAMPLE_MIN)
            return SAMPLE_MIN;
        return v;
    endfunction

    // Drop the coefficient fraction bits, rounding to nearest with ties going up.
    function automatic longint round_product(longint p, int shift);
        return (p + (longint'(1) <<< (shift - 1))) >>> shift;
    endfunction

    // Advance the filter by one sample and return the output it should give.
    function automatic sample_t filter_sample(sample_t x, logic active);
        longint f_coef;
        longint q_coef;
        longint band_prev;
        longint low_new;
        longint high_new;
        longint band_new;
        longint acc;
        if (!active)
            return x;
        f_coef    = longint'(cutoff_reg) * longint'(cutoff_reg);
        q_coef    = longint'(resonance_reg);
        band_prev = longint'(band_state);
        low_new   = clamp_sample(longint'(low_state)
                                 + round_product(f_coef * band_prev, COEF_F_SHIFT));
        high_new  = clamp_sample(longint'(x) - low_new
                                 - round_product(q_coef * band_prev, COEF_Q_SHIFT));
        band_new  = clamp_sample(band_prev + round_product(f_coef * high_new, COEF_F_SHIFT));
        low_state  = sample_t'(low_new);
        high_state = sample_t'(high_new);
        band_state = sample_t'(band_new);
        acc = 0;
        if (tap_mask_reg[TAP_LOW])
            acc += low_new;
        if (tap_mask_reg[TAP_HIGH])
            acc += high_new;
        if (tap_mask_reg[TAP_BAND])
            acc += band_new;
        if (tap_mask_reg[TAP_PEAK])
            acc += low_new - high_new;
        return sample_t'(clamp_sample(acc));
    endfunction

    // Moderate levels for half of the picks so the filter stays in its linear region, with
    // full-scale values and the two extremes mixed in to drive saturation.
    function automatic sample_t random_sample();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0)
            return sample_t'(SAMPLE_MAX);
        if (pick == 1)
            return sample_t'(SAMPLE_MIN);
        if (pick <= 4)
            return sample_t'($urandom);
        return sample_t'($signed($urandom_range(2 * UNIT)) - UNIT);
    endfunction

    function automatic code_t random_code();
        case ($urandom_range(4))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'd1;
            default: return code_t'($urandom);
        endcase
    endfunction

    // Offer one sample beat and hold it until the block takes it. Valid is left high
    // on return so a following beat can go out back to back; settle() lowers it.
    task automatic send_sample(sample_t s, logic active);
        while (!quiet && $urandom_range(99) < IDLE_PERCENT)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid       <= 1'b1;
        sample_ch.sample_in   <= s;
        sample_ch.note_active <= active;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        expected_out.push_back(filter_sample(s, active));
    endtask

    // Write one register and mirror the write in our own copy. Only the decoded
    // indexes take effect, and the tap mask keeps its low bits only.
    task automatic write_reg(cfg_index_t idx, cfg_data_t value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        case (idx)
            CFG_CUTOFF:    cutoff_reg    = value;
            CFG_RESONANCE: resonance_reg = value;
            CFG_TAP_MASK:  tap_mask_reg  = value[MASK_WIDTH-1:0];
            default:       ;
        endcase
    endtask

    // Stop offering samples and wait until every owed result has come back,
    // then give the block a few more cycles to go fully idle.
    task automatic settle();
        sample_ch.valid <= 1'b0;
        while (expected_out.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_filter(code_t cutoff, code_t resonance, mask_t taps);
        settle();
        write_reg(CFG_CUTOFF, cutoff);
        write_reg(CFG_RESONANCE, resonance);
        write_reg(CFG_TAP_MASK, cfg_data_t'(taps));
        cfg_ch.valid <= 1'b0;
    endtask

    // Register defaults after reset: a unit impulse and its decay through the
    // low-pass tap, then a negative unit sample.
    task automatic test_power_on_defaults();
        send_sample(UNIT, 1'b1);
        send_sample('0, 1'b1);
        send_sample('0, 1'b1);
        send_sample(-UNIT, 1'b1);
    endtask

    // Largest tuning with no damping and every tap summed drives the state and the
    // output into saturation at both rails. A zero cutoff then freezes low and band.
    task automatic test_saturation_extremes();
        set_filter(8'd255, 8'd0, 4'hF);
        send_sample(sample_t'(SAMPLE_MAX), 1'b1);
        send_sample(sample_t'(SAMPLE_MAX), 1'b1);
        send_sample(sample_t'(SAMPLE_MIN), 1'b1);
        send_sample(sample_t'(SAMPLE_MIN), 1'b1);
        set_filter(8'd0, 8'd255, 4'h2);
        send_sample(sample_t'(SAMPLE_MAX), 1'b1);
        send_sample('0, 1'b1);
    endtask

    // With the note off the input comes straight back and the state must be left
    // alone, which the active sample that follows shows.
    task automatic test_note_inactive();
        set_filter(8'd90, 8'd100, 4'hF);
        send_sample(sample_t'(SAMPLE_MAX), 1'b0);
        send_sample(sample_t'(SAMPLE_MIN), 1'b0);
        send_sample(random_sample(), 1'b0);
        send_sample('0, 1'b1);
    endtask

    // An empty tap mask outputs zero while the taps still move; the band tap
    // selected afterwards reveals where they went.
    task automatic test_empty_mask();
        set_filter(8'd128, 8'd128, 4'h0);
        send_sample(UNIT, 1'b1);
        send_sample(sample_t'(SAMPLE_MIN), 1'b1);
        set_filter(8'd128, 8'd128, 4'h4);
        send_sample('0, 1'b1);
    endtask

    // A tap mask written with spare high bits set keeps only its low bits, and a
    // write to the undecoded index must change nothing.
    task automatic test_register_write_edges();
        settle();
        write_reg(CFG_TAP_MASK, 8'hF6);
        write_reg(CFG_UNUSED, 8'hFF);
        write_reg(CFG_UNUSED, 8'h00);
        cfg_ch.valid <= 1'b0;
        send_sample(UNIT, 1'b1);
        send_sample(-UNIT, 1'b1);
    endtask

    // The receiver holds off for a long stretch while samples keep coming, so the
    // block fills up and has to stall its input.
    task automatic test_output_backpressure();
        set_filter(8'd100, 8'd64, 4'h5);
        hold_off_left = HOLD_OFF_LEN;
        repeat (PRESSURE_ITEMS) send_sample(random_sample(), $urandom_range(9) != 0);
    endtask

    // Phases of random samples, each under its own random filter setting. One phase
    // runs with no idling on either side.
    task automatic test_random_phases();
        int sent;
        int phase;
        int phase_len;
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            set_filter(random_code(), random_code(), mask_t'($urandom));
            quiet     = (phase == 2);
            phase_len = $urandom_range(60, 140);
            repeat (phase_len) send_sample(random_sample(), $urandom_range(9) != 0);
            sent  += phase_len;
            phase += 1;
        end
        quiet = 1'b0;
    endtask

    // Receiver side: random idle cycles, plus the long hold-off when one is asked for.
    always @(posedge clk)
    begin
        if (hold_off_left != 0)
        begin
            result_ch.ready <= 1'b0;
            hold_off_left   <= hold_off_left - 1;
        end
        else
            result_ch.ready <= quiet || ($urandom_range(99) >= IDLE_PERCENT);
    end

    // Every result beat is matched against the oldest owed output.
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (expected_out.size() == 0)
            begin
                $error("sample_out: expected nothing, got %0d", result_ch.sample_out);
                error_count++;
            end
            else if (result_ch.sample_out !== expected_out[0])
            begin
                $error("sample_out: expected %0d, got %0d",
                       expected_out[0], result_ch.sample_out);
                error_count++;
                void'(expected_out.pop_front());
            end
            else
                void'(expected_out.pop_front());
        end
    end

    // Watchdog: any beat on any channel counts as progress.
    always @(posedge clk)
    begin
        if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        rst_n                 = 1'b0;
        sample_ch.valid       = 1'b0;
        sample_ch.sample_in   = '0;
        sample_ch.note_active = 1'b0;
        result_ch.ready       = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.index          = CFG_CUTOFF;
        cfg_ch.data           = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        test_power_on_defaults();
        test_saturation_extremes();
        test_note_inactive();
        test_empty_mask();
        test_register_write_edges();
        test_output_backpressure();
        test_random_phases();

        settle();
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
